@@ sv/srq_pkg.sv @@
// ----------------------------------------------------------------------------
// srq_pkg: shared definitions for the strided ring queue
// Operation codes, register indexes, field widths and default sizes.
// ----------------------------------------------------------------------------
package srq_pkg;

    // Default sizing, handed to the top level as parameter defaults
    localparam int NUM_SLOTS_DEF = 256;
    localparam int CODE_BITS_DEF = 8;

    // Fixed field widths of the streams
    localparam int OP_W     = 3;
    localparam int SLOT_W   = 8;
    localparam int CODE_W   = 8;
    localparam int UNITS_W  = 12;
    localparam int FREE_W   = 24;
    localparam int SCOUNT_W = 9;

    // Slot size granule: 16 bytes
    localparam int UNIT_SHIFT = 4;

    // Register reset values
    localparam int SLOT_COUNT_RST = 256;
    localparam logic [UNITS_W-1:0] STRIDE_RST = 12'd4;

    // Configuration register indexes
    localparam logic REG_SLOT_COUNT   = 1'b0;
    localparam logic REG_STRIDE_UNITS = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC    = 3'd0,
        OP_ALLOC_TS = 3'd1,
        OP_COMPLETE = 3'd2,
        OP_IS_DONE  = 3'd3,
        OP_PEEK     = 3'd4,
        OP_FREE     = 3'd5,
        OP_STATUS   = 3'd6
    } op_t;

endpackage

@@ sv/spsc_strided_ring_queue.sv @@
// ----------------------------------------------------------------------------
// spsc_strided_ring_queue: single-producer, single-consumer slot ring
// Tracks head, tail and a per-slot header for a ring of fixed-stride slots.
// ----------------------------------------------------------------------------
// Usage
//   s_*   : operation stream. s_tuser carries the opcode; s_tdata the slot
//           index and the category/subcategory codes stored on allocation.
//   m_*   : one result transfer per operation, in order. m_tuser is ok.
//   cfg_* : register writes (slot count, stride in 16-byte units). Always
//           ready; write only while no operation is in flight.
// Timing: an operation is held in the input register, then decoded and
//   applied as its result is loaded into the output register for m_*.
// Throughput: one operation per cycle while the output is not stalled.
//   Each operation touches head, tail and one slot header in a single
//   pass; header flags sit in flip-flops, the codes in a one-write,
//   one-read memory that is read at the next tail every cycle, so
//   back-to-back operations see each other's updates.
// Reset: head = tail = 0, every slot unallocated, slot count 256 (clamped
//   to the slot store), stride 4 units. No clearing pass is needed.
// Stall: while m_tready is low the result is held in the output register;
//   one more operation waits in the input register, then s_tready drops.
// ----------------------------------------------------------------------------
module spsc_strided_ring_queue
    import srq_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF,
    parameter int CODE_BITS = CODE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // operation stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // slot_index, category, subcategory
    input  logic [OP_W-1:0]      s_tuser,   // opcode
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // slot, entry_category, entry_subcategory, entry_timestamped,
    // entry_units, is_empty, is_full, free_bytes (bit 63 zero)
    output logic [63:0]          m_tdata,
    output logic                 m_tuser,   // ok
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [UNITS_W-1:0]   cfg_data
);

    localparam int IDX_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W   = $clog2(NUM_SLOTS + 1);
    localparam int CMP_W   = (CNT_W > SCOUNT_W) ? CNT_W : SCOUNT_W;
    localparam int RNG_W   = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
    localparam int STORE_W = (CODE_BITS < CODE_W) ? CODE_BITS : CODE_W;
    localparam int MEM_W   = 2 * STORE_W + 1;
    localparam int PROD_W  = (CNT_W + UNITS_W > 21) ? (CNT_W + UNITS_W) : 21;
    localparam int SAT_BIT = FREE_W - UNIT_SHIFT;
    localparam int EFF_RST = (SLOT_COUNT_RST > NUM_SLOTS) ? NUM_SLOTS : SLOT_COUNT_RST;

    // ------------------------------------------------------------------
    // Configuration: slot count is clamped once, at write time
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]   eff_cnt_reg;
    logic [UNITS_W-1:0] stride_reg;
    logic [CMP_W-1:0]   cfg_cnt;

    assign cfg_ready = 1'b1;
    assign cfg_cnt   = CMP_W'(cfg_data[SCOUNT_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_cnt_reg <= CNT_W'(EFF_RST);
            stride_reg  <= STRIDE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_SLOT_COUNT)
            begin
                if (cfg_cnt < CMP_W'(2))
                    eff_cnt_reg <= CNT_W'(2);
                else if (cfg_cnt > CMP_W'(NUM_SLOTS))
                    eff_cnt_reg <= CNT_W'(NUM_SLOTS);
                else
                    eff_cnt_reg <= CNT_W'(cfg_cnt);
            end
            else
                stride_reg <= cfg_data;
        end
    end

    function automatic logic [CNT_W-1:0] advance(input logic [IDX_W-1:0] i,
                                                 input logic [CNT_W-1:0] cnt);
        logic [CNT_W:0] n;
        n = (CNT_W + 1)'(i) + 1'b1;
        return (n >= (CNT_W + 1)'(cnt)) ? '0 : CNT_W'(n);
    endfunction

    // ------------------------------------------------------------------
    // Input register and output register handshake
    // ------------------------------------------------------------------
    logic                 in_valid_reg;
    op_t                  in_op_reg;
    logic [SLOT_W-1:0]    in_idx_reg;
    logic [CODE_W-1:0]    in_cat_reg;
    logic [CODE_W-1:0]    in_sub_reg;
    logic                 out_valid_reg;
    logic                 fire;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg  <= op_t'(s_tuser);
            in_idx_reg <= s_tdata[7:0];
            in_cat_reg <= s_tdata[15:8];
            in_sub_reg <= s_tdata[23:16];
        end
    end

    // ------------------------------------------------------------------
    // Ring state: pointers and header flags in flops
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [IDX_W-1:0]     tail_reg, tail_next;
    logic [NUM_SLOTS-1:0] alloc_reg, alloc_next;
    logic [NUM_SLOTS-1:0] done_reg, done_next;

    // Code memory: {timestamped, subcategory, category}; read at next tail
    logic [MEM_W-1:0]     code_mem [NUM_SLOTS];
    logic [MEM_W-1:0]     mem_rd_reg;
    logic [MEM_W-1:0]     byp_data_reg;
    logic                 byp_reg;
    logic [MEM_W-1:0]     tail_codes;
    logic                 mem_we;
    logic [MEM_W-1:0]     mem_wdata;

    // ------------------------------------------------------------------
    // Single-pass operation decode
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]     idx;
    logic                 idx_in_range;
    logic [CNT_W-1:0]     head_adv;
    logic [CNT_W-1:0]     tail_adv;
    logic                 r_ok;
    logic [SLOT_W-1:0]    r_slot;
    logic [CODE_W-1:0]    r_cat;
    logic [CODE_W-1:0]    r_sub;
    logic                 r_ts;
    logic [UNITS_W-1:0]   r_units;
    logic [CNT_W-1:0]     nh_adv;
    logic [CNT_W-1:0]     nt_ext;
    logic [CNT_W-1:0]     free_slots;
    logic [PROD_W-1:0]    prod;
    logic [FREE_W-1:0]    r_free;
    logic                 r_empty;
    logic                 r_full;

    assign idx          = IDX_W'(in_idx_reg);
    assign idx_in_range = (RNG_W'(in_idx_reg) < RNG_W'(NUM_SLOTS));
    assign head_adv     = advance(head_reg, eff_cnt_reg);
    assign tail_adv     = advance(tail_reg, eff_cnt_reg);
    assign tail_codes   = byp_reg ? byp_data_reg : mem_rd_reg;
    assign mem_wdata    = {in_op_reg == OP_ALLOC_TS,
                           STORE_W'(in_sub_reg), STORE_W'(in_cat_reg)};

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        alloc_next = alloc_reg;
        done_next  = done_reg;
        mem_we     = 1'b0;
        r_ok       = 1'b0;
        r_slot     = '0;
        r_cat      = '0;
        r_sub      = '0;
        r_ts       = 1'b0;
        r_units    = '0;
        if (fire)
        begin
            unique case (in_op_reg)
                OP_ALLOC, OP_ALLOC_TS:
                begin
                    if (head_adv != CNT_W'(tail_reg) &&
                        !alloc_reg[head_reg] && !done_reg[head_reg])
                    begin
                        alloc_next[head_reg] = 1'b1;
                        mem_we    = 1'b1;
                        r_ok      = 1'b1;
                        r_slot    = SLOT_W'(head_reg);
                        r_cat     = CODE_W'(mem_wdata[STORE_W-1:0]);
                        r_sub     = CODE_W'(mem_wdata[2*STORE_W-1:STORE_W]);
                        r_ts      = mem_wdata[MEM_W-1];
                        r_units   = stride_reg;
                        head_next = IDX_W'(head_adv);
                    end
                end
                OP_COMPLETE:
                begin
                    r_slot = in_idx_reg;
                    if (idx_in_range && alloc_reg[idx])
                    begin
                        done_next[idx] = 1'b1;
                        r_ok = 1'b1;
                    end
                end
                OP_IS_DONE:
                begin
                    r_slot = in_idx_reg;
                    r_ok   = idx_in_range && done_reg[idx];
                end
                OP_PEEK, OP_FREE:
                begin
                    if (head_reg != tail_reg && alloc_reg[tail_reg] && done_reg[tail_reg])
                    begin
                        r_ok    = 1'b1;
                        r_slot  = SLOT_W'(tail_reg);
                        r_cat   = CODE_W'(tail_codes[STORE_W-1:0]);
                        r_sub   = CODE_W'(tail_codes[2*STORE_W-1:STORE_W]);
                        r_ts    = tail_codes[MEM_W-1];
                        r_units = stride_reg;
                        if (in_op_reg == OP_FREE)
                        begin
                            alloc_next[tail_reg] = 1'b0;
                            done_next[tail_reg]  = 1'b0;
                            tail_next = IDX_W'(tail_adv);
                        end
                    end
                end
                OP_STATUS:
                    r_ok = 1'b1;
                default:
                    r_ok = 1'b0;
            endcase
        end
    end

    // Status after this operation's update
    assign nh_adv  = advance(head_next, eff_cnt_reg);
    assign nt_ext  = CNT_W'(tail_next);
    assign r_empty = (head_next == tail_next);
    assign r_full  = (nh_adv == nt_ext);

    always_comb
    begin
        if (nh_adv > nt_ext)
            free_slots = eff_cnt_reg - nh_adv + nt_ext;
        else if (nh_adv < nt_ext)
            free_slots = nt_ext - nh_adv;
        else
            free_slots = '0;
    end

    assign prod   = PROD_W'(free_slots) * PROD_W'(stride_reg);
    assign r_free = (|prod[PROD_W-1:SAT_BIT]) ? '1
                                              : {prod[SAT_BIT-1:0], {UNIT_SHIFT{1'b0}}};

    // ------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            alloc_reg <= '0;
            done_reg  <= '0;
            byp_reg   <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            alloc_reg <= alloc_next;
            done_reg  <= done_next;
            byp_reg   <= mem_we && (head_reg == tail_next);
        end
    end

    // Code memory: write at head on allocation, read every cycle at next tail
    always_ff @(posedge clk)
    begin
        if (mem_we)
            code_mem[head_reg] <= mem_wdata;
        mem_rd_reg   <= code_mem[tail_next];
        byp_data_reg <= mem_wdata;
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [63:0] out_data_reg;
    logic        out_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_ok_reg   <= r_ok;
            out_data_reg <= {1'b0, r_free, r_full, r_empty, r_units, r_ts,
                             r_sub, r_cat, r_slot};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_ok_reg;

endmodule
